### sv/fpr_pkg.sv
// Shared types and constants for the framed packet receiver.
`default_nettype none

package fpr_pkg;

   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int IDX_W      = 6;
   localparam int HCNT_W     = 3;
   localparam int LEN_W      = 6;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h23;
   localparam logic [BYTE_W-1:0] MIN_FRAME = 8'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd0;
   localparam logic [STATUS_W-1:0] ST_LEN_ERR = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CSUM    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOADDR  = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MY_ADDR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_LEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_LEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic                hunt_clear;
      logic                hdr_step;
      logic                read_start;
      logic                tick;
      logic                len_load;
      logic                body_store;
      logic                drain_start;
      logic                drain_next;
      logic                rsp_load;
      logic [STATUS_W-1:0] rsp_code;
      logic                rsp_last;
   } fpr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic enable;
      logic op;
      logic header_done;
      logic first_byte;
      logic len_ok;
      logic at_checksum;
      logic sum_ok;
      logic addressed;
      logic timeout_hit;
      logic drain_last;
   } fpr_stat_type;

endpackage

`default_nettype wire

### sv/fpr_ctrl.sv
// Frame receiver controller: phase sequencing, handshakes and drain control.
`default_nettype none

module fpr_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   input  fpr_pkg::fpr_stat_type stat,
   output fpr_pkg::fpr_cmd_type  cmd
);
   import fpr_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_HUNT     = 3'd1;
   localparam logic [2:0] S_READ     = 3'd2;
   localparam logic [2:0] S_DRAIN_RD = 3'd3;
   localparam logic [2:0] S_DRAIN_WR = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = out_free &&
                       (state_ff == S_IDLE || state_ff == S_HUNT || state_ff == S_READ);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_code = ST_PAYLOAD;
      case (state_ff)
         S_IDLE, S_HUNT, S_READ: begin
            if (accept) begin
               if (!stat.enable) begin
                  state_in       = S_IDLE;
                  cmd.hunt_clear = 1'b1;
               end else if (state_ff != S_READ) begin
                  // hunting for the header run; ticks are ignored
                  state_in = S_HUNT;
                  if (!stat.op) begin
                     cmd.hdr_step = 1'b1;
                     if (stat.header_done) begin
                        cmd.read_start = 1'b1;
                        state_in       = S_READ;
                     end
                  end
               end else if (stat.op) begin
                  cmd.tick = 1'b1;
                  if (stat.timeout_hit) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_code   = ST_TIMEOUT;
                     cmd.rsp_last   = 1'b1;
                     cmd.hunt_clear = 1'b1;
                     state_in       = S_HUNT;
                  end
               end else if (stat.first_byte) begin
                  if (stat.len_ok) begin
                     cmd.len_load = 1'b1;
                  end else begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_code   = ST_LEN_ERR;
                     cmd.rsp_last   = 1'b1;
                     cmd.hunt_clear = 1'b1;
                     state_in       = S_HUNT;
                  end
               end else if (stat.at_checksum) begin
                  cmd.hunt_clear = 1'b1;
                  if (!stat.sum_ok) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_code = ST_CSUM;
                     cmd.rsp_last = 1'b1;
                     state_in     = S_HUNT;
                  end else if (!stat.addressed) begin
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_code = ST_NOADDR;
                     cmd.rsp_last = 1'b1;
                     state_in     = S_HUNT;
                  end else begin
                     cmd.drain_start = 1'b1;
                     state_in        = S_DRAIN_RD;
                  end
               end else begin
                  cmd.body_store = 1'b1;
               end
            end
         end
         S_DRAIN_RD: begin
            // store read in flight
            state_in = S_DRAIN_WR;
         end
         S_DRAIN_WR: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_code = ST_PAYLOAD;
               cmd.rsp_last = stat.drain_last;
               if (stat.drain_last) begin
                  state_in = S_HUNT;
               end else begin
                  cmd.drain_next = 1'b1;
                  state_in       = S_DRAIN_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output beat valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/fpr_datapath.sv
// Frame receiver datapath: registers, counters, checks, payload store, result register.
`default_nettype none

module fpr_datapath #(
   parameter int MAX_FRAME_LEN = 32,
   parameter int HEADER_COUNT  = 5
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_we,
   input  wire  [fpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [fpr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire  [fpr_pkg::BYTE_W-1:0]        rx_byte,
   input  wire                               op,
   input  fpr_pkg::fpr_cmd_type              cmd,
   output fpr_pkg::fpr_stat_type             stat,
   output logic [fpr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fpr_pkg::BYTE_W-1:0]        rsp_payload,
   output logic [fpr_pkg::BYTE_W-1:0]        rsp_source,
   output logic                              rsp_last
);
   import fpr_pkg::*;

   localparam int AW = $clog2(MAX_FRAME_LEN);
   localparam logic [BYTE_W-1:0] MAX_LEN_LIM = BYTE_W'(MAX_FRAME_LEN);
   localparam logic [HCNT_W-1:0] HDR_RUN     = HCNT_W'(HEADER_COUNT);

   // configuration
   logic              enable_ff;
   logic [BYTE_W-1:0] my_addr_ff;
   logic [LEN_W-1:0]  min_len_ff;
   logic [LEN_W-1:0]  max_len_ff;
   logic [TICK_W-1:0] timeout_ff;

   // frame state
   logic [HCNT_W-1:0] hcount_ff, hcount_in;
   logic [IDX_W-1:0]  bidx_ff, bidx_in;
   logic [LEN_W-1:0]  flen_ff;
   logic [BYTE_W-1:0] sum_ff;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;
   logic [BYTE_W-1:0] sender_ff;
   logic              addressed_ff;
   logic [AW-1:0]     drain_idx_ff;

   logic [BYTE_W-1:0] store_mem [MAX_FRAME_LEN];
   logic [BYTE_W-1:0] store_q_ff;

   logic [BYTE_W-1:0] lo_lim, hi_lim;
   logic [HCNT_W-1:0] hcount_inc;
   logic [IDX_W-1:0]  store_wa;
   logic [LEN_W-1:0]  last_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff  <= 1'b0;
         my_addr_ff <= '0;
         min_len_ff <= LEN_W'(5);
         max_len_ff <= LEN_W'(32);
         timeout_ff <= TICK_W'(1000);
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLE:  enable_ff  <= csr_wdata[0];
            REG_MY_ADDR: my_addr_ff <= csr_wdata[BYTE_W-1:0];
            REG_MIN_LEN: min_len_ff <= csr_wdata[LEN_W-1:0];
            REG_MAX_LEN: max_len_ff <= csr_wdata[LEN_W-1:0];
            REG_TIMEOUT: timeout_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // effective length limits
   always_comb begin
      lo_lim = {2'b00, min_len_ff};
      if (lo_lim < MIN_FRAME) lo_lim = MIN_FRAME;
      hi_lim = {2'b00, max_len_ff};
      if (hi_lim > MAX_LEN_LIM) hi_lim = MAX_LEN_LIM;
   end

   assign hcount_inc = (rx_byte == HDR_BYTE) ? hcount_ff + HCNT_W'(1) : '0;
   assign elapsed_in = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TICK_W'(1);
   assign store_wa   = bidx_ff - IDX_W'(3);
   assign last_pos   = flen_ff - LEN_W'(5);

   assign stat.enable      = enable_ff;
   assign stat.op          = op;
   assign stat.header_done = (hcount_inc == HDR_RUN);
   assign stat.first_byte  = (bidx_ff == '0);
   assign stat.len_ok      = (rx_byte >= lo_lim) && (rx_byte <= hi_lim);
   assign stat.at_checksum = ({1'b0, bidx_ff} + 7'd1) >= {1'b0, flen_ff};
   assign stat.sum_ok      = (rx_byte == sum_ff);
   assign stat.addressed   = addressed_ff;
   assign stat.timeout_hit = (elapsed_in >= timeout_ff);
   assign stat.drain_last  = (drain_idx_ff == last_pos[AW-1:0]);

   // header count and byte index
   always_comb begin
      hcount_in = hcount_ff;
      bidx_in   = bidx_ff;
      if (cmd.hunt_clear) begin
         hcount_in = '0;
         bidx_in   = '0;
      end
      if (cmd.hdr_step) hcount_in = hcount_inc;
      if (cmd.read_start) begin
         hcount_in = '0;
         bidx_in   = '0;
      end
      if (cmd.len_load)   bidx_in = IDX_W'(1);
      if (cmd.body_store) bidx_in = bidx_ff + IDX_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcount_ff    <= '0;
         bidx_ff      <= '0;
         flen_ff      <= '0;
         sum_ff       <= '0;
         elapsed_ff   <= '0;
         sender_ff    <= '0;
         addressed_ff <= 1'b0;
         drain_idx_ff <= '0;
      end else begin
         hcount_ff <= hcount_in;
         bidx_ff   <= bidx_in;
         if (cmd.read_start) begin
            elapsed_ff <= '0;
            sum_ff     <= '0;
         end
         if (cmd.tick) elapsed_ff <= elapsed_in;
         if (cmd.len_load) begin
            flen_ff <= rx_byte[LEN_W-1:0];
            sum_ff  <= rx_byte;
         end
         if (cmd.body_store) begin
            sum_ff <= sum_ff + rx_byte;
            if (bidx_ff == IDX_W'(1)) sender_ff <= rx_byte;
            if (bidx_ff == IDX_W'(2)) addressed_ff <= (rx_byte == my_addr_ff);
         end
         if (cmd.drain_start) drain_idx_ff <= '0;
         if (cmd.drain_next)  drain_idx_ff <= drain_idx_ff + AW'(1);
      end
   end

   // payload store: written on body bytes, read at the drain index
   always_ff @(posedge clock) begin
      if (cmd.body_store && bidx_ff > IDX_W'(2)) begin
         store_mem[store_wa[AW-1:0]] <= rx_byte;
      end
      store_q_ff <= store_mem[drain_idx_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status  <= cmd.rsp_code;
         rsp_last    <= cmd.rsp_last;
         rsp_payload <= (cmd.rsp_code == ST_PAYLOAD) ? store_q_ff : '0;
         rsp_source  <= (cmd.rsp_code == ST_LEN_ERR || cmd.rsp_code == ST_TIMEOUT) ?
                        '0 : sender_ff;
      end
   end

endmodule

`default_nettype wire

### sv/framed_packet_receiver_top.sv
// Top level of the framed packet receiver: controller, datapath and checks.
// Results: a status result is registered in the cycle its byte or tick is taken and
//   is offered on the next cycle; each payload result needs a store read first.
// Throughput: one input beat per cycle while the result register is free; a good
//   addressed frame blocks input while its L-4 payload entries are read from the
//   store, one entry per result over the single read port.
// Reset: synchronous, active high; state and CSRs return to defaults, block idles.
`default_nettype none

module framed_packet_receiver_top #(
   parameter int MAX_FRAME_LEN = 32,
   parameter int HEADER_COUNT  = 5
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // rx_byte
   input  wire         req_tuser,   // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // payload_byte, source_address
   output logic [2:0]  rsp_tuser,   // status
   output logic        rsp_tlast,   // last
   input  wire         csr_we,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata
);
   import fpr_pkg::*;

   fpr_cmd_type       cmd;
   fpr_stat_type      stat;
   logic [BYTE_W-1:0] rsp_payload;
   logic [BYTE_W-1:0] rsp_source;

   fpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   fpr_datapath #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN),
      .HEADER_COUNT  (HEADER_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rx_byte     (req_tdata),
      .op          (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_status  (rsp_tuser),
      .rsp_payload (rsp_payload),
      .rsp_source  (rsp_source),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {rsp_source, rsp_payload};

   // single result register: no input beat while a result is stalled
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   // a status result is a run of one with no payload byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_PAYLOAD |-> rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("status result malformed");

   // length and timeout results carry no sender
   a_err_no_source: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_LEN_ERR || rsp_tuser == ST_TIMEOUT)
      |-> rsp_tdata[15:8] == 8'd0)
      else $error("source on length or timeout result");

endmodule

`default_nettype wire
